// ----- rtl/spatial_weighted_centroid_score_unit_defines.svh -----
// Assertion macros shared by the centroid score unit.
`ifndef SPATIAL_WEIGHTED_CENTROID_SCORE_UNIT_DEFINES_SVH
`define SPATIAL_WEIGHTED_CENTROID_SCORE_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SWC_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define SWC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- rtl/swc_pkg.sv -----
// Package: widths, payload types and the request record of the centroid score unit.
package swc_pkg;
	localparam int FRAC_BITS = 16;
	localparam int QDEPTH = 4;
	localparam int QAW = 2;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO_GAMMA = 2'd1;
	localparam logic [1:0] ST_ZERO_DEV = 2'd2;

	// Request passed from front to back.
	typedef struct packed {
		logic [19:0] pixel;
		logic [7:0]  cls;
		logic [32:0] mag;
		logic [31:0] weight;
		logic [31:0] dev;
		logic [63:0] gamma;
		logic        close_n;
		logic        close_p;
	} req_t;
endpackage

// ----- rtl/swc_front.sv -----
// Front end: classifies items, forms |x-m| and gamma, queues the requests.
module swc_front
	import swc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [19:0]  pixel_index,
	input  logic [7:0]   class_index,
	input  logic [31:0]  x,
	input  logic [31:0]  m,
	input  logic [31:0]  w,
	input  logic [31:0]  sd,
	input  logic [31:0]  alpha,
	input  logic [31:0]  beta,
	input  logic         lastf,
	input  logic         lastn,
	output logic         req_valid,
	input  logic         req_ready,
	output req_t         req
);
	req_t             mem_q [QDEPTH];
	logic [QAW:0]     cnt_q;
	logic [QAW-1:0]   wp_q, rp_q;
	logic signed [32:0] diff;
	logic [63:0]      ab;
	req_t             nreq;
	logic             push, pop;

	assign in_ready  = (cnt_q != (QAW+1)'(QDEPTH));
	assign push      = in_valid && in_ready;
	assign req_valid = (cnt_q != '0);
	assign pop       = req_valid && req_ready;
	assign req       = mem_q[rp_q];

	// classify and precompute
	always_comb begin
		diff = {x[31], x} - {m[31], m};
		ab = {32'd0, alpha} * {32'd0, beta};
		nreq.pixel   = pixel_index;
		nreq.cls     = class_index;
		nreq.mag     = diff[32] ? 33'(-diff) : 33'(diff);
		nreq.weight  = w;
		nreq.dev     = sd;
		nreq.gamma   = ab >> FRAC_BITS;
		nreq.close_n = lastf || lastn;
		nreq.close_p = lastn;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= nreq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end
endmodule

// ----- rtl/swc_div.sv -----
// Iterative restoring divider: 128-bit dividend by 64-bit divisor, saturating.
module swc_div
	import swc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  n_hi,
	input  logic [63:0]  n_lo,
	input  logic [63:0]  d,
	output logic         done,
	output logic [63:0]  q
);
	logic [63:0] r_q, lo_q, q_q, d_q;
	logic [6:0]  cnt_q;
	logic        busy_q, sat_q, done_q;
	logic [64:0] sh;
	logic [64:0] sub;

	assign sh = {r_q, lo_q[63]};
	assign sub = sh - {1'b0, d_q};
	assign done = done_q;
	assign q = sat_q ? '1 : q_q;

	// one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= n_hi;
			lo_q <= n_lo;
			d_q <= d;
			q_q <= '0;
			sat_q <= (n_hi >= d);
		end else if (busy_q) begin
			lo_q <= {lo_q[62:0], 1'b0};
			if (!sub[64]) begin
				r_q <= sub[63:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= sh[63:0];
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

// ----- rtl/swc_back.sv -----
// Back end: term, neighbor scaling, accumulation and final score.
module swc_back
	import swc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_ready,
	input  req_t         req,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [19:0]  out_pixel,
	output logic [7:0]   out_class,
	output logic [47:0]  score,
	output logic [1:0]   status
);
	`include "spatial_weighted_centroid_score_unit_defines.svh"

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SQ   = 9'b000000010,
		S_MW0  = 9'b000000100,
		S_MW1  = 9'b000001000,
		S_TDIV = 9'b000010000,
		S_NB0  = 9'b000100000,
		S_NB1  = 9'b001000000,
		S_SDIV = 9'b010000000,
		S_OUT  = 9'b100000000
	} st_t;

	st_t          st_q;
	req_t         r_q;
	logic [63:0]  sq_q, dd_q;
	logic [127:0] acc_q;
	logic [1:0]   mstep_q;
	logic [63:0]  fsum_q, wsum_q, gtot_q;
	logic         zdev_q;
	logic         div_start;
	logic [63:0]  div_hi, div_lo, div_d, div_q;
	logic         div_done;
	logic [64:0]  add_f, add_w, add_g;
	logic [63:0]  term, contrib;
	logic [31:0]  mul_a, mul_b;
	logic [63:0]  pp;
	logic [1:0]   pp_pos;
	logic [127:0] addend, msum;
	logic         out_load;

	swc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.n_hi(div_hi), .n_lo(div_lo), .d(div_d), .done(div_done), .q(div_q)
	);

	assign req_ready = (st_q == S_IDLE);
	assign out_load = (st_q == S_OUT) && (!out_valid || out_ready);

	// one 32x32 partial product per cycle, summed into a 128-bit accumulator
	always_comb begin
		mul_a = sq_q[31:0];
		mul_b = r_q.weight;
		pp_pos = 2'd0;
		case (st_q)
			S_MW1: begin
				mul_a = sq_q[63:32];
				pp_pos = 2'd1;
			end
			S_NB0: begin
				mul_a = mstep_q[0] ? fsum_q[63:32] : fsum_q[31:0];
				mul_b = mstep_q[1] ? r_q.gamma[63:32] : r_q.gamma[31:0];
				pp_pos = {1'b0, mstep_q[0]} + {1'b0, mstep_q[1]};
			end
			default: ;
		endcase
		pp = {32'd0, mul_a} * {32'd0, mul_b};
		case (pp_pos)
			2'd1: addend = {32'd0, pp, 32'd0};
			2'd2: addend = {pp, 64'd0};
			default: addend = {64'd0, pp};
		endcase
		msum = acc_q + addend;
	end

	always_comb begin
		contrib = (acc_q[127:64] >> FRAC_BITS) != 64'd0 ? '1
			: 64'(acc_q >> FRAC_BITS);
		term = (r_q.dev == 32'd0) ? '1 : div_q;
		add_f = {1'b0, fsum_q} + {1'b0, term};
		add_w = {1'b0, wsum_q} + {1'b0, contrib};
		add_g = {1'b0, gtot_q} + {1'b0, r_q.gamma};
	end

	// divider operand selection
	always_comb begin
		div_start = 1'b0;
		div_hi = msum[127:64];
		div_lo = msum[63:0];
		div_d = dd_q;
		case (st_q)
			S_MW1: div_start = (r_q.dev != 32'd0);
			S_NB1: begin
				div_start = r_q.close_p && (add_g[64] ? 1'b1 : add_g[63:0] != 64'd0);
				div_hi = 64'(add_w[64] ? '1 : add_w[63:0]) >> (64 - FRAC_BITS);
				div_lo = (add_w[64] ? '1 : add_w[63:0]) << FRAC_BITS;
				div_d = add_g[64] ? '1 : add_g[63:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: if (req_valid && req_ready) r_q <= req;
			S_SQ: begin
				sq_q <= 64'(r_q.mag) * 64'(r_q.mag);
				dd_q <= 64'(r_q.dev) * 64'(r_q.dev);
				acc_q <= '0;
			end
			S_MW0: acc_q <= msum;
			S_TDIV: acc_q <= '0;
			S_NB0: acc_q <= msum;
			default: ;
		endcase
	end

	// sequencer and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			mstep_q <= '0;
			fsum_q <= '0;
			wsum_q <= '0;
			gtot_q <= '0;
			zdev_q <= 1'b0;
			out_valid <= 1'b0;
			out_pixel <= '0;
			out_class <= '0;
			score <= '0;
			status <= ST_OK;
		end else begin
			if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
			case (st_q)
				S_IDLE: if (req_valid && req_ready) st_q <= S_SQ;
				S_SQ: st_q <= S_MW0;
				S_MW0: st_q <= S_MW1;
				S_MW1: st_q <= S_TDIV;
				S_TDIV: begin
					if (r_q.dev == 32'd0 || div_done) begin
						fsum_q <= add_f[64] ? '1 : add_f[63:0];
						if (r_q.dev == 32'd0) zdev_q <= 1'b1;
						st_q <= r_q.close_n ? S_NB0 : S_IDLE;
					end
				end
				S_NB0: begin
					mstep_q <= mstep_q + 2'd1;
					if (mstep_q == 2'd3) st_q <= S_NB1;
				end
				S_NB1: begin
					wsum_q <= add_w[64] ? '1 : add_w[63:0];
					gtot_q <= add_g[64] ? '1 : add_g[63:0];
					fsum_q <= '0;
					st_q <= !r_q.close_p ? S_IDLE : (div_start ? S_SDIV : S_OUT);
				end
				S_SDIV: if (div_done) st_q <= S_OUT;
				S_OUT: begin
					// wait here while the previous result is still held
					if (out_load) begin
						out_valid <= 1'b1;
						out_pixel <= r_q.pixel;
						out_class <= r_q.cls;
						if (gtot_q == 64'd0) begin
							score <= '0;
							status <= ST_ZERO_GAMMA;
						end else begin
							score <= (div_q[63:48] != 16'd0) ? '1 : div_q[47:0];
							status <= zdev_q ? ST_ZERO_DEV : ST_OK;
						end
						wsum_q <= '0;
						gtot_q <= '0;
						zdev_q <= 1'b0;
						fsum_q <= '0;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// handshake and output checks
	`SWC_ASSERT(a_idle_ready, req_ready, st_q == S_IDLE, "ready outside idle")
	`SWC_ASSERT_NEXT(a_out_follows, st_q == S_OUT, out_valid, "result not raised")
	`SWC_ASSERT(a_status_code, out_valid, status != 2'd3, "bad status code")
endmodule

// ----- rtl/spatial_weighted_centroid_score_unit.sv -----
// Top level of the spatially weighted centroid score unit.
// Input stream s_axis_*: one (neighbor, feature) element per request.
//   tdata packs x, m, w, sd, alpha, beta; tuser carries pixel and class;
//   tlast closes the pixel/class run, and tuser's top bit closes the neighbor.
// Output stream m_axis_*: one score per run, sent on its last element.
// The front end forms |x-m| and gamma and queues up to four requests, so the
//   feeder keeps streaming while the back end computes.
// Back end per element: square, two multiply steps, then the 64-step term divider;
//   an element with a zero deviation skips the divider.
// A closing neighbor adds four multiply steps and the accumulate.
// A closing run adds the score division (skipped when the gamma total is zero)
//   and a load of the output register.
// The result register holds its value until m_axis_tready; the back end keeps
//   working and only waits when its next result is ready, after which the
//   queue fills and drops s_axis_tready.
// Reset clears the queue, the accumulators and the output valid flag.
module spatial_weighted_centroid_score_unit
	import swc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// x[31:0], m[63:32], w[95:64], sd[127:96], alpha[159:128], beta[191:160]
	input  logic [191:0] s_axis_tdata,
	// pixel_index[19:0], class_index[27:20], last_feature[28]
	input  logic [28:0]  s_axis_tuser,
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_pixel[19:0], out_class[27:20], score[75:28], status[77:76], zero pad
	output logic [79:0]  m_axis_tdata
);
	req_t        req;
	logic        req_valid, req_ready;
	logic [19:0] out_pixel;
	logic [7:0]  out_class;
	logic [47:0] score;
	logic [1:0]  status;

	swc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.pixel_index(s_axis_tuser[19:0]), .class_index(s_axis_tuser[27:20]),
		.x(s_axis_tdata[31:0]), .m(s_axis_tdata[63:32]),
		.w(s_axis_tdata[95:64]), .sd(s_axis_tdata[127:96]),
		.alpha(s_axis_tdata[159:128]), .beta(s_axis_tdata[191:160]),
		.lastf(s_axis_tuser[28]), .lastn(s_axis_tlast),
		.req_valid(req_valid), .req_ready(req_ready), .req(req)
	);

	swc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_pixel(out_pixel), .out_class(out_class), .score(score), .status(status)
	);

	assign m_axis_tdata = {2'b00, status, score, out_class, out_pixel};
endmodule

// ----- bench/tb.sv -----
// Testbench for the spatially weighted centroid score unit: stream stimulus and scoreboard.
`timescale 1ns / 100ps

module tb
	import swc_pkg::*;
;

	// One element of a pixel/class run
	typedef struct {
		logic [19:0] pixel;
		logic [7:0]  cls;
		logic [31:0] x;
		logic [31:0] m;
		logic [31:0] w;
		logic [31:0] sd;
		logic [31:0] alpha;
		logic [31:0] beta;
		logic        last_f;
		logic        last_n;
	} elem_t;

	// One score result
	typedef struct {
		logic [19:0] pixel;
		logic [7:0]  cls;
		logic [47:0] score;
		logic [1:0]  status;
	} score_t;

	// Scoreboard: running centroid distance model and queue of pending scores
	class score_board;
		logic [63:0] feat_acc;
		logic [63:0] wsum_acc;
		logic [63:0] gamma_acc;
		bit          dev_zero;
		score_t      pending[$];
		int          errors;
		int          shown;

		function new();
			feat_acc = 0;
			wsum_acc = 0;
			gamma_acc = 0;
			dev_zero = 0;
			errors = 0;
			shown = 0;
		endfunction

		function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
			logic [64:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[64] ? '1 : s[63:0];
		endfunction

		// Note an accepted request; queue a score on the run's last element
		function void note_request(elem_t e);
			logic signed [32:0] d;
			logic [32:0]  mag;
			logic [127:0] num;
			logic [127:0] q;
			logic [63:0]  term;
			logic [63:0]  g;
			logic [127:0] p;
			logic [63:0]  contrib;
			score_t       r;
			d = $signed({e.x[31], e.x}) - $signed({e.m[31], e.m});
			mag = d[32] ? -d : d;
			if (e.sd == 0) begin
				term = '1;
				dev_zero = 1;
			end else begin
				num = {62'd0, 66'(mag) * 66'(mag)} * {96'd0, e.w};
				q = num / ({64'd0, e.sd} * {96'd0, e.sd});
				term = (q[127:64] != 0) ? '1 : q[63:0];
			end
			feat_acc = add_sat(feat_acc, term);
			if (e.last_f || e.last_n) begin
				g = ({32'd0, e.alpha} * {32'd0, e.beta}) >> FRAC_BITS;
				p = {64'd0, feat_acc} * {64'd0, g};
				p = p >> FRAC_BITS;
				contrib = (p[127:64] != 0) ? '1 : p[63:0];
				wsum_acc = add_sat(wsum_acc, contrib);
				gamma_acc = add_sat(gamma_acc, g);
				feat_acc = 0;
			end
			if (!e.last_n) return;
			r.pixel = e.pixel;
			r.cls = e.cls;
			if (gamma_acc == 0) begin
				r.score = 0;
				r.status = ST_ZERO_GAMMA;
			end else begin
				q = ({64'd0, wsum_acc} << FRAC_BITS) / {64'd0, gamma_acc};
				r.score = (q > 128'hFFFF_FFFF_FFFF) ? '1 : q[47:0];
				r.status = dev_zero ? ST_ZERO_DEV : ST_OK;
			end
			pending.push_back(r);
			feat_acc = 0;
			wsum_acc = 0;
			gamma_acc = 0;
			dev_zero = 0;
		endfunction

		// Compare a received score with the oldest pending one
		function void check_result(score_t got);
			score_t exp_r;
			if (pending.size() == 0) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("unexpected result pixel=%h class=%h score=%h status=%0d",
						got.pixel, got.cls, got.score, got.status);
				end
				return;
			end
			exp_r = pending.pop_front();
			if (got.pixel !== exp_r.pixel || got.cls !== exp_r.cls ||
					got.score !== exp_r.score || got.status !== exp_r.status) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("mismatch exp pixel=%h class=%h score=%h status=%0d",
						exp_r.pixel, exp_r.cls, exp_r.score, exp_r.status);
					$display("         got pixel=%h class=%h score=%h status=%0d",
						got.pixel, got.cls, got.score, got.status);
				end
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [191:0] s_axis_tdata;
	logic [28:0]  s_axis_tuser;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [79:0]  m_axis_tdata;

	score_board sb;
	int  cycle_count = 0;
	bit  no_idle;
	bit  sink_run;

	spatial_weighted_centroid_score_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Timeout guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result sink with random stalls
	always @(posedge clk) begin
		score_t got;
		if (m_axis_tvalid && m_axis_tready) begin
			got.pixel = m_axis_tdata[19:0];
			got.cls = m_axis_tdata[27:20];
			got.score = m_axis_tdata[75:28];
			got.status = m_axis_tdata[77:76];
			sb.check_result(got);
		end
		if (sink_run)
			m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 36);
	end

	// Send one request, idling at random before it
	task automatic send_elem(elem_t e);
		while (!no_idle && $urandom_range(99) < 36) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {e.beta, e.alpha, e.sd, e.w, e.m, e.x};
		s_axis_tuser <= {e.last_f, e.cls, e.pixel};
		s_axis_tlast <= e.last_n;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(e);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(32'h3_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic elem_t rand_elem(logic [19:0] pix, logic [7:0] cl);
		elem_t e;
		e.pixel = pix;
		e.cls = cl;
		e.x = rand_word();
		e.m = rand_word();
		e.w = rand_word();
		e.sd = ($urandom_range(19) == 0) ? 32'd0 : (rand_word() | 32'd1);
		e.alpha = ($urandom_range(9) == 0) ? 32'd0 : rand_word();
		e.beta = rand_word();
		e.last_f = 0;
		e.last_n = 0;
		return e;
	endfunction

	// Directed element with explicit fields
	task automatic send_dir(logic [31:0] x, logic [31:0] m, logic [31:0] w,
			logic [31:0] sd, logic [31:0] a, logic [31:0] b, logic lf, logic ln);
		elem_t e;
		e.pixel = $urandom;
		e.cls = $urandom;
		e.x = x;
		e.m = m;
		e.w = w;
		e.sd = sd;
		e.alpha = a;
		e.beta = b;
		e.last_f = lf;
		e.last_n = ln;
		send_elem(e);
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		int sent;
		int nn;
		int nf;
		elem_t e;
		logic [19:0] pix;
		logic [7:0]  cl;
		sb = new();
		no_idle = 0;
		sink_run = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		sink_run <= 1'b1;
		@(posedge clk);

		// Directed: extremes, zero deviation, zero gamma, saturation, implicit close
		send_dir(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0001_0000,
			32'h0001_0000, 32'h0001_0000, 1, 1);
		send_dir(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1);
		send_dir(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1,
			32'd1, 32'd1, 1, 1);
		send_dir(32'h1234_5678, 32'h0, 32'h0001_0000, 32'h0,
			32'h0001_0000, 32'h0002_0000, 1, 1);
		send_dir(32'h1234_5678, 32'h0, 32'h0001_0000, 32'h0001_0000,
			32'h0, 32'hFFFF_FFFF, 1, 1);
		send_dir(32'h1234_5678, 32'h0, 32'h0001_0000, 32'h0,
			32'h0, 32'h0, 0, 1);
		send_dir(32'h0003_0000, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000,
			32'h0, 32'h0, 0, 0);
		send_dir(32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000, 32'h0000_4000,
			32'h0001_0000, 32'h0000_8000, 1, 0);
		send_dir(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF,
			32'h0003_0000, 32'h0001_0000, 0, 1);
		send_dir(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'h0000_0001, 1, 1);

		// Pause until every pending score is out
		wait_drain();

		// Random runs of neighbors and features
		sent = 0;
		while (sent < 550) begin
			no_idle = (sent >= 200 && sent < 300);
			pix = $urandom;
			cl = $urandom;
			nn = $urandom_range(4, 1);
			for (int n = 0; n < nn; n++) begin
				nf = $urandom_range(4, 1);
				for (int f = 0; f < nf; f++) begin
					e = rand_elem(pix, cl);
					e.last_f = (f == nf - 1) ? ($urandom_range(7) != 0) : ($urandom_range(15) == 0);
					e.last_n = (n == nn - 1) && (f == nf - 1);
					send_elem(e);
					sent++;
				end
			end
			if (sent > 350 && sent < 365) wait_drain();
		end
		s_axis_tvalid <= 1'b0;

		// Drain and settle
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
